@@ rtl/median_average_sensor_filter_defines.svh @@
// Assertion macros shared by the median/average sensor filter RTL.
// Self-contained; included by the modules that carry concurrent checks.
`ifndef MEDIAN_AVERAGE_SENSOR_FILTER_DEFINES_SVH
`define MEDIAN_AVERAGE_SENSOR_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSAF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSAF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

@@ rtl/msaf_pkg.sv @@
// Shared widths, register indexes and controller/datapath interface types
// for the median/average sensor filter. No dependencies.
package msaf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int WLEN_W     = 5;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_EN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WLEN      = 8'd3;

    localparam logic              RST_FILTER_EN = 1'b1;
    localparam logic              RST_GAIN_EN   = 1'b0;
    localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd256;
    localparam logic [WLEN_W-1:0] RST_WLEN      = 5'd8;

    typedef struct packed {
        logic load;
        logic write;
        logic read;
        logic accum;
        logic div_init;
        logic div_step;
        logic div_out;
        logic mul;
        logic sat;
    } cmd_t;

    typedef struct packed {
        logic filter_en;
        logic gain_en;
    } status_t;

endpackage

@@ rtl/msaf_ctrl.sv @@
// Controller state machine of the median/average sensor filter.
// Depends on msaf_pkg and the assertion macro header.
`include "median_average_sensor_filter_defines.svh"

module msaf_ctrl #(
    parameter int LEN_W = 5,
    parameter int SUM_W = 21
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               in_ready,
    input  logic               out_free,
    output logic               emit,
    input  msaf_pkg::status_t  status,
    input  logic [LEN_W-1:0]   n_len,
    output msaf_pkg::cmd_t     cmd
);

    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WR   = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_DIVI = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_DIVO = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_SAT  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [LEN_W-1:0]  rcnt_reg, rcnt_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              in_accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && in_ready;

    always_comb begin
        state_next = state_reg;
        rcnt_next  = rcnt_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (status.filter_en) begin
                        state_next = S_WR;
                    end else if (status.gain_en) begin
                        state_next = S_MUL;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WR: begin
                cmd.write  = 1'b1;
                rcnt_next  = '0;
                state_next = S_RD;
            end
            S_RD: begin
                cmd.read  = 1'b1;
                cmd.accum = (rcnt_reg != '0);
                if (rcnt_reg == n_len - LEN_W'(1)) begin
                    state_next = S_ACC;
                end else begin
                    rcnt_next = rcnt_reg + LEN_W'(1);
                end
            end
            S_ACC: begin
                cmd.accum  = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == DCNT_W'(SUM_W - 1)) begin
                    state_next = S_DIVO;
                end else begin
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
            end
            S_DIVO: begin
                cmd.div_out = 1'b1;
                state_next  = status.gain_en ? S_MUL : S_DONE;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_SAT;
            end
            S_SAT: begin
                cmd.sat    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rcnt_reg  <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    `MSAF_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, in_accept, !in_ready)
    `MSAF_ASSERT_NXT(a_bypass_goes_done, aclk, aresetn, in_accept && !status.filter_en && !status.gain_en, state_reg == S_DONE)

endmodule

@@ rtl/msaf_dpath.sv @@
// Datapath of the median/average sensor filter: configuration registers,
// window store, accumulator, iterative divider and gain stage. Uses msaf_pkg.
`include "median_average_sensor_filter_defines.svh"

module msaf_dpath #(
    parameter int WINDOW_MAX = 16,
    parameter int LEN_W      = 5,
    parameter int SUM_W      = 21
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [msaf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msaf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [3*msaf_pkg::SAMPLE_W-1:0]     in_data,
    input  msaf_pkg::cmd_t                      cmd,
    output msaf_pkg::status_t                   status,
    output logic [LEN_W-1:0]                    n_len,
    output logic [msaf_pkg::SAMPLE_W-1:0]       reading,
    output logic                                saturated
);

    localparam int SW    = msaf_pkg::SAMPLE_W;
    localparam int PTR_W = $clog2(WINDOW_MAX);

    logic                          filter_en_reg;
    logic                          gain_en_reg;
    logic [msaf_pkg::GAIN_W-1:0]   gain_reg;
    logic [msaf_pkg::WLEN_W-1:0]   wlen_reg;

    logic [SW-1:0]                 mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         vld_reg;
    logic [PTR_W-1:0]              wptr_reg;
    logic [PTR_W-1:0]              rd_ptr_reg;
    logic [SW-1:0]                 rdata_reg;
    logic                          rvld_reg;

    logic [SUM_W-1:0]              acc_reg;
    logic [LEN_W-1:0]              rem_reg;
    logic [SUM_W-1:0]              quo_reg;
    logic [SW-1:0]                 val_reg;
    logic                          sat_reg;
    logic [msaf_pkg::PROD_W-1:0]   prod_reg;

    logic [SW-1:0]                 s_a, s_b, s_c, med;
    logic [LEN_W:0]                shifted;
    logic                          qbit;

    function automatic logic [SW-1:0] med3(input logic [SW-1:0] a,
                                           input logic [SW-1:0] b,
                                           input logic [SW-1:0] c);
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c > hi) begin
            return hi;
        end else if (c > lo) begin
            return c;
        end
        return lo;
    endfunction

    assign s_a = in_data[SW-1:0];
    assign s_b = in_data[2*SW-1:SW];
    assign s_c = in_data[3*SW-1:2*SW];
    assign med = med3(s_a, s_b, s_c);

    assign status.filter_en = filter_en_reg;
    assign status.gain_en   = gain_en_reg;
    assign reading          = val_reg;
    assign saturated        = sat_reg;

    always_comb begin
        if (wlen_reg == '0) begin
            n_len = LEN_W'(1);
        end else if (int'(wlen_reg) > WINDOW_MAX) begin
            n_len = LEN_W'(WINDOW_MAX);
        end else begin
            n_len = LEN_W'(wlen_reg);
        end
    end

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign qbit    = (shifted >= {1'b0, n_len});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_en_reg <= msaf_pkg::RST_FILTER_EN;
            gain_en_reg   <= msaf_pkg::RST_GAIN_EN;
            gain_reg      <= msaf_pkg::RST_GAIN;
            wlen_reg      <= msaf_pkg::RST_WLEN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msaf_pkg::REG_FILTER_EN: filter_en_reg <= cfg_data[0];
                msaf_pkg::REG_GAIN_EN:   gain_en_reg   <= cfg_data[0];
                msaf_pkg::REG_GAIN:      gain_reg      <= cfg_data[msaf_pkg::GAIN_W-1:0];
                msaf_pkg::REG_WLEN:      wlen_reg      <= cfg_data[msaf_pkg::WLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            wptr_reg <= '0;
        end else if (cmd.write) begin
            vld_reg[wptr_reg] <= 1'b1;
            if (wptr_reg == PTR_W'(WINDOW_MAX - 1)) begin
                wptr_reg <= '0;
            end else begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[wptr_reg] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rdata_reg <= mem[rd_ptr_reg];
            rvld_reg  <= vld_reg[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            rd_ptr_reg <= wptr_reg;
        end else if (cmd.read) begin
            if (rd_ptr_reg == '0) begin
                rd_ptr_reg <= PTR_W'(WINDOW_MAX - 1);
            end else begin
                rd_ptr_reg <= rd_ptr_reg - PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            acc_reg <= '0;
        end else if (cmd.accum) begin
            acc_reg <= acc_reg + (rvld_reg ? SUM_W'(rdata_reg) : SUM_W'(0));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= acc_reg;
        end else if (cmd.div_step) begin
            if (qbit) begin
                rem_reg <= LEN_W'(shifted - {1'b0, n_len});
            end else begin
                rem_reg <= shifted[LEN_W-1:0];
            end
            quo_reg <= {quo_reg[SUM_W-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= msaf_pkg::PROD_W'(val_reg) * msaf_pkg::PROD_W'(gain_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg <= filter_en_reg ? med : s_a;
            sat_reg <= 1'b0;
        end else if (cmd.div_out) begin
            val_reg <= quo_reg[SW-1:0];
        end else if (cmd.sat) begin
            if (|prod_reg[msaf_pkg::PROD_W-1:SW+8]) begin
                val_reg <= '1;
                sat_reg <= 1'b1;
            end else begin
                val_reg <= prod_reg[SW+7:8];
            end
        end
    end

    `MSAF_ASSERT_NXT(a_write_sets_valid, aclk, aresetn, cmd.write, vld_reg[$past(wptr_reg)])
    `MSAF_ASSERT_IMP(a_mean_fits, aclk, aresetn, cmd.div_out, quo_reg[SUM_W-1:SW] == '0)

endmodule

@@ rtl/median_average_sensor_filter.sv @@
// Filtered item: the result is the mean of the newest n window entries, where n is the
// effective window length; the window sum is 21 bits wide at WINDOW_MAX 16. Gain, when enabled,
// scales the result. One item at a time; the next input can be taken in the cycle after the
// result enters the output register. The window is read back one entry a cycle and the divider
// works one bit a cycle. Reset is synchronous: it restores the registers' reset values and
// clears the window valid bits (no clearing pass).
`include "median_average_sensor_filter_defines.svh"

module median_average_sensor_filter #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata fields from bit 0: sample_a[15:0], sample_b[31:16], sample_c[47:32]
    input  logic [3*msaf_pkg::SAMPLE_W-1:0]      s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata fields from bit 0: reading[15:0]
    output logic [msaf_pkg::SAMPLE_W-1:0]        m_tdata,
    // m_tuser fields from bit 0: saturated[0]
    output logic [0:0]                           m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [msaf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [msaf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NMAX  = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;
    localparam int LEN_W = $clog2(NMAX + 1);
    localparam int SUM_W = msaf_pkg::SAMPLE_W + LEN_W;

    msaf_pkg::cmd_t                 cmd;
    msaf_pkg::status_t              status;
    logic [LEN_W-1:0]               n_len;
    logic [msaf_pkg::SAMPLE_W-1:0]  reading;
    logic                           saturated;
    logic                           emit;
    logic                           out_free;

    logic [msaf_pkg::SAMPLE_W-1:0]  m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tvalid_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tvalid  = m_tvalid_reg;

    msaf_ctrl #(
        .LEN_W (LEN_W),
        .SUM_W (SUM_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .emit     (emit),
        .status   (status),
        .n_len    (n_len),
        .cmd      (cmd)
    );

    msaf_dpath #(
        .WINDOW_MAX (WINDOW_MAX),
        .LEN_W      (LEN_W),
        .SUM_W      (SUM_W)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .n_len     (n_len),
        .reading   (reading),
        .saturated (saturated)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= reading;
            m_tuser_reg <= saturated;
        end
    end

    `MSAF_ASSERT_IMP(a_emit_into_free_slot, aclk, aresetn, emit, !m_tvalid_reg || m_tready)

endmodule

@@ dv/median_average_sensor_filter_tb.sv @@
// Self-checking testbench for median_average_sensor_filter: drives sample triples and
// register writes, predicts every reading and saturation flag, and compares each transfer.
// Depends on msaf_pkg and the filter RTL.
module median_average_sensor_filter_tb;

    localparam int SAMPLE_W     = msaf_pkg::SAMPLE_W;
    localparam int GAIN_W       = msaf_pkg::GAIN_W;
    localparam int WLEN_W       = msaf_pkg::WLEN_W;
    localparam int PROD_W       = msaf_pkg::PROD_W;
    localparam int CFG_IDX_W    = msaf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = msaf_pkg::CFG_DATA_W;
    localparam int WINDOW_MAX   = 16;
    localparam int PTR_W        = $clog2(WINDOW_MAX);
    localparam int SUM_W        = SAMPLE_W + PTR_W + 1;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 64;
    localparam int CONFIG_EVERY = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = msaf_pkg::REG_WLEN + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

    typedef struct {
        logic [SAMPLE_W-1:0] reading;
        logic                saturated;
    } reading_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [3*SAMPLE_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   filter_on;
    logic                   gain_on;
    logic [GAIN_W-1:0]      gain;
    logic [WLEN_W-1:0]      wlen;
    logic [SAMPLE_W-1:0]    window [WINDOW_MAX];
    logic [PTR_W-1:0]       wr_ptr;

    reading_t readings_due [$];
    int       fault_count        = 0;
    int       sender_idle_pct    = 32;
    int       receiver_stall_pct = 65;
    bit       sample_offered     = 1'b0;
    bit       reg_write_open     = 1'b0;

    median_average_sensor_filter #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] a, b, c);
        logic [SAMPLE_W-1:0] lo, hi, med, value;
        logic [PTR_W-1:0]    idx;
        logic [SUM_W-1:0]    sum;
        logic [PROD_W-1:0]   prod;
        int                  n;
        reading_t            r;
        value = a;
        if (filter_on) begin
            lo  = (a < b) ? a : b;
            hi  = (a < b) ? b : a;
            med = (c > hi) ? hi : ((c > lo) ? c : lo);
            n   = (wlen == 0) ? 1 : ((wlen > WINDOW_MAX) ? WINDOW_MAX : int'(wlen));
            idx = wr_ptr;
            window[idx] = med;
            wr_ptr = wr_ptr + 1'b1;
            sum = '0;
            for (int k = 0; k < n; k++) begin
                sum = sum + window[idx];
                idx = idx - 1'b1;
            end
            value = SAMPLE_W'(sum / n);
        end
        r.saturated = 1'b0;
        if (gain_on) begin
            prod = PROD_W'(value) * PROD_W'(gain);
            if (prod[PROD_W-1:SAMPLE_W+8] != 0) begin
                value = '1;
                r.saturated = 1'b1;
            end else begin
                value = prod[SAMPLE_W+7:8];
            end
        end
        r.reading = value;
        return r;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] a, b, c);
        if (reg_write_open) begin
            cfg_valid <= 1'b0;
            reg_write_open = 1'b0;
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            if (sample_offered) begin
                s_tvalid <= 1'b0;
                sample_offered = 1'b0;
            end
            @(posedge aclk);
        end
        s_tdata  <= {c, b, a};
        s_tvalid <= 1'b1;
        sample_offered = 1'b1;
        do @(posedge aclk); while (!s_tready);
        readings_due.push_back(predict_reading(a, b, c));
    endtask

    task automatic drain_readings();
        if (sample_offered) begin
            s_tvalid <= 1'b0;
            sample_offered = 1'b0;
        end
        while (readings_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        reg_write_open = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            msaf_pkg::REG_FILTER_EN: filter_on = data[0];
            msaf_pkg::REG_GAIN_EN:   gain_on   = data[0];
            msaf_pkg::REG_GAIN:      gain      = data[GAIN_W-1:0];
            msaf_pkg::REG_WLEN:      wlen      = data[WLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_values();
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0064, 16'h07D0, 16'h7530);
        send_sample(16'h0064, 16'h7530, 16'h07D0);
        send_sample(16'h07D0, 16'h0064, 16'h7530);
        send_sample(16'h07D0, 16'h7530, 16'h0064);
        send_sample(16'h7530, 16'h0064, 16'h07D0);
        send_sample(16'h7530, 16'h07D0, 16'h0064);
        send_sample(16'h0005, 16'h0005, 16'h0009);
        send_sample(16'h0009, 16'h0005, 16'h0009);
    endtask

    task automatic test_register_extremes();
        drain_readings();
        write_reg(msaf_pkg::REG_WLEN, 16'h0000);
        send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
        drain_readings();
        write_reg(msaf_pkg::REG_WLEN, 16'hFFFF);
        send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(16'h0001, 16'hFFFE, 16'h5555);
        drain_readings();
        write_reg(msaf_pkg::REG_GAIN_EN, 16'h0001);
        write_reg(msaf_pkg::REG_GAIN, 16'hFFFF);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain_readings();
        write_reg(msaf_pkg::REG_GAIN, 16'h0000);
        send_sample(16'hAAAA, 16'h5555, 16'hFFFF);
        drain_readings();
        write_reg(msaf_pkg::REG_GAIN, 16'h0001);
        write_reg(msaf_pkg::REG_WLEN, 16'h0001);
        send_sample(16'h1234, 16'h4321, 16'hFFFF);
        drain_readings();
        write_reg(msaf_pkg::REG_FILTER_EN, 16'hFFFE);
        write_reg(msaf_pkg::REG_GAIN, 16'h0100);
        send_sample(16'hFFFF, 16'h0000, 16'h0000);
        drain_readings();
        write_reg(msaf_pkg::REG_GAIN, 16'h0101);
        send_sample(16'hFFFF, 16'h0000, 16'h0000);
        send_sample(16'h00FE, 16'hFFFF, 16'hFFFF);
        drain_readings();
        write_reg(REG_UNUSED_FIRST, 16'hFFFF);
        write_reg(REG_UNUSED_LAST, 16'h0000);
        send_sample(16'hABCD, 16'h0000, 16'h0000);
        drain_readings();
        write_reg(msaf_pkg::REG_FILTER_EN, 16'h0001);
        write_reg(msaf_pkg::REG_GAIN_EN, 16'hFFFE);
        write_reg(msaf_pkg::REG_WLEN, 16'h0010);
        send_sample(16'h0000, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000, 16'h0000);
        drain_readings();
        write_reg(msaf_pkg::REG_WLEN, 16'h0011);
        send_sample(16'hC000, 16'h4000, 16'h8000);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        logic [SAMPLE_W-1:0] a, b, c, base;
        logic [GAIN_W-1:0]   g;
        logic [WLEN_W-1:0]   w;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % CONFIG_EVERY == 0) begin
                drain_readings();
                case ($urandom_range(4))
                    0:       g = 16'h0000;
                    1:       g = 16'h0100;
                    2:       g = 16'hFFFF;
                    3:       g = 16'($urandom_range(200, 320));
                    default: g = 16'($urandom);
                endcase
                w = ($urandom_range(99) < 60) ? 5'($urandom_range(1, 16))
                                              : 5'($urandom_range(0, 31));
                write_reg(msaf_pkg::REG_FILTER_EN,
                          {15'($urandom), 1'($urandom_range(99) < 85)});
                write_reg(msaf_pkg::REG_GAIN_EN,
                          {15'($urandom), 1'($urandom_range(99) < 40)});
                write_reg(msaf_pkg::REG_GAIN, g);
                write_reg(msaf_pkg::REG_WLEN, {11'($urandom), w});
                if ($urandom_range(3) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                              16'($urandom));
            end
            base = 16'($urandom);
            case ($urandom_range(3))
                0: begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                    c = 16'($urandom);
                end
                1: begin
                    a = base ^ 16'($urandom_range(255));
                    b = base ^ 16'($urandom_range(255));
                    c = base ^ 16'($urandom_range(255));
                end
                2: begin
                    a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    b = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    c = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
                default: begin
                    a = base;
                    b = $urandom_range(1) ? base : 16'($urandom);
                    c = $urandom_range(1) ? base : 16'($urandom);
                end
            endcase
            send_sample(a, b, c);
        end
    endtask

    always @(posedge aclk) begin
        reading_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (readings_due.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected reading transfer: got %h sat %b",
                             m_tdata, m_tuser[0]);
            end else begin
                due = readings_due.pop_front();
                if (m_tdata !== due.reading || m_tuser[0] !== due.saturated) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("reading mismatch: expected %h sat %b, got %h sat %b",
                                 due.reading, due.saturated, m_tdata, m_tuser[0]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        filter_on = msaf_pkg::RST_FILTER_EN;
        gain_on   = msaf_pkg::RST_GAIN_EN;
        gain      = msaf_pkg::RST_GAIN;
        wlen      = msaf_pkg::RST_WLEN;
        wr_ptr    = '0;
        foreach (window[i]) window[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_register_extremes();
        test_random_traffic(32, 65, 160);
        test_random_traffic(65, 32, 160);
        test_random_traffic(0, 0, 160);
        drain_readings();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
